// File: hdl/circular_deque_defines.svh
// ---------------------------------------------------------------------------
// circular_deque assertion macros
// shared property wrappers for the checker
// ---------------------------------------------------------------------------
`ifndef CIRCULAR_DEQUE_DEFINES_SVH
`define CIRCULAR_DEQUE_DEFINES_SVH

// same-cycle implication
`define CDQ_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("circular_deque same-cycle check failed");

// next-cycle implication
`define CDQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("circular_deque next-cycle check failed");

`endif

// File: hdl/cdq_pkg.sv
// ---------------------------------------------------------------------------
// cdq_pkg
// types and codes shared by the deque cells and the top level
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package cdq_pkg;

  typedef logic [2:0] mode_t;

  localparam mode_t MODE_PUSH_FRONT = 3'd0;
  localparam mode_t MODE_PUSH_BACK  = 3'd1;
  localparam mode_t MODE_POP_FRONT  = 3'd2;
  localparam mode_t MODE_POP_BACK   = 3'd3;
  localparam mode_t MODE_STATUS     = 3'd4;

  localparam int          WORD_W      = 32;
  localparam int          LIMIT_W     = 5;
  localparam logic [4:0]  LIMIT_RESET = 5'd16;

  typedef logic signed [WORD_W-1:0] word_t;

  localparam word_t EMPTY_WORD = -32'sd1;

  typedef struct packed {
    logic  apply;
    mode_t mode;
    word_t value;
  } cell_ctl_t;

endpackage

// File: hdl/circular_deque.sv
// ---------------------------------------------------------------------------
// circular_deque
// double-ended queue of signed words held in a row of shifting cells
// ---------------------------------------------------------------------------
// usage:
//   input channel (in_valid / in_stall) carries one operation beat: mode and
//   value. modes: push front, push back, pop front, pop back, status only;
//   other codes behave as status only.
//   result channel (out_valid / out_stall) returns one beat per operation:
//   ok flag, front and rear words (-1 when empty), empty and full flags.
//   cfg_valid / cfg_ready writes the entry limit (clamped to DEPTH); write it
//   only while no operation is outstanding. cfg_ready is always high.
// timing:
//   the cell row updates at the accepting edge; the deque then enters the
//   load state, in which the result register loads from the cell row and
//   out_valid rises. in_stall is high in the load state, so no new operation is taken until the result is loaded.
// reset:
//   all cells empty, limit back to 16, no result pending.
// stall:
//   a stalled result holds; in_stall stays high until it is taken.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module circular_deque #(
  parameter int DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [2:0]          in_mode,
  input  logic signed [31:0]  in_value,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_ok,
  output logic signed [31:0]  out_front_value,
  output logic signed [31:0]  out_rear_value,
  output logic                out_is_empty,
  output logic                out_is_full,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [4:0]          cfg_data
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > cdq_pkg::LIMIT_W) ? CNT_W : cdq_pkg::LIMIT_W;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_LOAD = 1'b1;

  logic                  st_r, st_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [4:0]            max_r;
  logic                  out_valid_r;
  logic                  ok_r;
  logic                  res_ok_r;
  cdq_pkg::word_t        res_front_r, res_rear_r;
  logic                  res_empty_r, res_full_r;

  logic                  in_acc;
  logic                  op_ok;
  logic                  is_push, is_pop;
  logic [CMP_W-1:0]      count_ext, max_ext, limit;
  logic                  has_room;
  cdq_pkg::cell_ctl_t    ctl;
  cdq_pkg::word_t        rear_or;

  cdq_pkg::word_t        data_w [DEPTH];
  logic                  occ_w  [DEPTH];
  cdq_pkg::word_t        rear_w [DEPTH];

  assign cfg_ready = 1'b1;
  assign in_stall  = (st_r == ST_LOAD) || (out_valid_r && out_stall);
  assign in_acc    = in_valid && !in_stall;

  assign count_ext = CMP_W'(count_r);
  assign max_ext   = CMP_W'(max_r);
  assign limit     = (max_ext > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : max_ext;
  assign has_room  = count_ext < limit;

  assign is_push = (in_mode == cdq_pkg::MODE_PUSH_FRONT) ||
                   (in_mode == cdq_pkg::MODE_PUSH_BACK);
  assign is_pop  = (in_mode == cdq_pkg::MODE_POP_FRONT) ||
                   (in_mode == cdq_pkg::MODE_POP_BACK);
  assign op_ok   = is_push ? has_room : (is_pop ? (count_r != '0) : 1'b1);

  assign ctl.apply = in_acc && op_ok && (is_push || is_pop);
  assign ctl.mode  = in_mode;
  assign ctl.value = in_value;

  always_comb begin
    count_nxt = count_r;
    if (ctl.apply) begin
      if (is_push) begin
        count_nxt = count_r + CNT_W'(1);
      end else begin
        count_nxt = count_r - CNT_W'(1);
      end
    end
  end

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      cdq_pkg::word_t l_data, r_data;
      logic           l_occ, r_occ;
      if (gi == 0) begin : g_first
        assign l_data = in_value;
        assign l_occ  = 1'b1;
      end else begin : g_mid
        assign l_data = data_w[gi-1];
        assign l_occ  = occ_w[gi-1];
      end
      if (gi == DEPTH - 1) begin : g_last
        assign r_data = '0;
        assign r_occ  = 1'b0;
      end else begin : g_inner
        assign r_data = data_w[gi+1];
        assign r_occ  = occ_w[gi+1];
      end
      cdq_cell u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .left_data  (l_data),
        .left_occ   (l_occ),
        .right_data (r_data),
        .right_occ  (r_occ),
        .data       (data_w[gi]),
        .occ        (occ_w[gi]),
        .rear_word  (rear_w[gi])
      );
    end
  endgenerate

  always_comb begin
    rear_or = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rear_or = rear_or | rear_w[i];
    end
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE: begin
        if (in_acc) begin
          st_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        st_nxt = ST_IDLE;
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      count_r     <= '0;
      max_r       <= cdq_pkg::LIMIT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      st_r    <= st_nxt;
      count_r <= count_nxt;
      if (cfg_valid && cfg_ready) begin
        max_r <= cfg_data;
      end
      if (st_r == ST_LOAD) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      ok_r <= op_ok;
    end
    if (st_r == ST_LOAD) begin
      res_ok_r    <= ok_r;
      res_front_r <= occ_w[0] ? data_w[0] : cdq_pkg::EMPTY_WORD;
      res_rear_r  <= occ_w[0] ? rear_or : cdq_pkg::EMPTY_WORD;
      res_empty_r <= (count_r == '0);
      res_full_r  <= (count_ext >= limit);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_ok          = res_ok_r;
  assign out_front_value = res_front_r;
  assign out_rear_value  = res_rear_r;
  assign out_is_empty    = res_empty_r;
  assign out_is_full     = res_full_r;

endmodule

// File: hdl/cdq_cell.sv
// ---------------------------------------------------------------------------
// cdq_cell
// one deque slot: holds a word and an occupied flag, shifts with neighbours
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module cdq_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  cdq_pkg::cell_ctl_t ctl,
  input  cdq_pkg::word_t    left_data,
  input  logic              left_occ,
  input  cdq_pkg::word_t    right_data,
  input  logic              right_occ,
  output cdq_pkg::word_t    data,
  output logic              occ,
  output cdq_pkg::word_t    rear_word
);

  cdq_pkg::word_t data_r, data_nxt;
  logic           occ_r, occ_nxt;

  always_comb begin
    data_nxt = data_r;
    occ_nxt  = occ_r;
    if (ctl.apply) begin
      unique case (ctl.mode)
        cdq_pkg::MODE_PUSH_FRONT: begin
          data_nxt = left_data;
          occ_nxt  = left_occ;
        end
        cdq_pkg::MODE_PUSH_BACK: begin
          if (!occ_r && left_occ) begin
            data_nxt = ctl.value;
            occ_nxt  = 1'b1;
          end
        end
        cdq_pkg::MODE_POP_FRONT: begin
          data_nxt = right_data;
          occ_nxt  = right_occ;
        end
        cdq_pkg::MODE_POP_BACK: begin
          if (occ_r && !right_occ) begin
            occ_nxt = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 1'b0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data      = data_r;
  assign occ       = occ_r;
  // last occupied slot drives its word onto the rear bus
  assign rear_word = (occ_r && !right_occ) ? data_r : '0;

endmodule

// File: hdl/cdq_checker.sv
// ---------------------------------------------------------------------------
// cdq_checker
// port-level checks on the deque result channel, bound to the top level
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "circular_deque_defines.svh"

module cdq_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [31:0] out_front_value,
  input logic signed [31:0] out_rear_value,
  input logic               out_is_empty
);

  // stalled result beat holds
  `CDQ_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_front_value))

  // empty result carries the marker word on both ends
  `CDQ_ASSERT_NOW(a_empty_marker, out_valid && out_is_empty, (out_front_value == -32'sd1) && (out_rear_value == -32'sd1))

  // an accepted beat is not answered in the next cycle
  `CDQ_ASSERT_NEXT(a_acc_gap, in_valid && !in_stall, !out_valid && in_stall)

  // taken result is not followed by another at once
  `CDQ_ASSERT_NEXT(a_out_gap, out_valid && !out_stall, !out_valid)

endmodule

bind circular_deque cdq_checker u_cdq_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_front_value (out_front_value),
  .out_rear_value  (out_rear_value),
  .out_is_empty    (out_is_empty)
);
